[rtl/core/framebuffer_text_console_unit_defines.svh]
// Assertion macros shared by the checker of the text console unit.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef FRAMEBUFFER_TEXT_CONSOLE_UNIT_DEFINES_SVH
`define FRAMEBUFFER_TEXT_CONSOLE_UNIT_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define FBTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define FBTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/fbtc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fbtc_pkg;

  localparam int CUR_W     = 13;
  localparam int IDX_W     = 24;
  localparam int COLOR_W   = 32;
  localparam int MASK_W    = 8;
  localparam int CODE_W    = 8;
  localparam int FADDR_W   = 12;
  localparam int OP_W      = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CELL_SH   = 3;

  localparam logic [CUR_W-1:0] CELL_WIDTH = 13'd8;
  localparam logic [CUR_W-1:0] MIN_PITCH  = 13'd8;
  localparam logic [CUR_W-1:0] MAX_PITCH  = 13'd4096;
  localparam logic [CUR_W-1:0] MIN_HEIGHT = 13'd16;
  localparam logic [CUR_W-1:0] MAX_HEIGHT = 13'd4096;

  localparam logic [CUR_W-1:0]   PITCH_RST  = 13'd640;
  localparam logic [CUR_W-1:0]   HEIGHT_RST = 13'd480;
  localparam logic [COLOR_W-1:0] TEXT_RST   = 32'h00FF_FFFF;
  localparam logic [COLOR_W-1:0] BACK_RST   = 32'h0000_0000;
  localparam logic [COLOR_W-1:0] ERASE_COLOR = 32'h0000_0000;

  localparam logic [MASK_W-1:0] MASK_FULL  = 8'hFF;
  localparam logic [MASK_W-1:0] MASK_NONE  = 8'h00;
  localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'd10;

  localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
  localparam logic [OP_W-1:0] OP_SPACE = 3'd1;
  localparam logic [OP_W-1:0] OP_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
  localparam logic [OP_W-1:0] OP_FONT  = 3'd4;

  localparam logic KIND_ROW  = 1'b0;
  localparam logic KIND_FILL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PITCH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACK   = 4'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PFILL,
    S_CHAR,
    S_START,
    S_ROW,
    S_ADV,
    S_WRAP,
    S_LF,
    S_LFFILL,
    S_SFILL,
    S_BS,
    S_CLR,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic font_wr;
    logic push_fill;
    logic push_row;
    logic flush;
    logic start_rows;
    logic erase;
    logic next_row;
    logic adv_x;
    logic line_feed;
    logic bs_move;
  } ctrl_cmd_t;

  typedef struct packed {
    logic y_ge_h;
    logic x_ge_pitch;
    logic at_origin;
    logic code_nl;
    logic row_ok;
    logic row_last;
    logic can_push;
  } ctrl_status_t;

endpackage

`default_nettype wire

[rtl/core/fbtc_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface fbtc_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [fbtc_pkg::OP_W-1:0]    operation;
  logic [fbtc_pkg::CODE_W-1:0]  char_code;
  logic [fbtc_pkg::FADDR_W-1:0] font_address;
  logic [fbtc_pkg::MASK_W-1:0]  font_byte;

  modport source (output valid, operation, char_code, font_address, font_byte, input ready);
  modport sink   (input valid, operation, char_code, font_address, font_byte, output ready);
endinterface

interface fbtc_res_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [fbtc_pkg::IDX_W-1:0]   pixel_index;
  logic [fbtc_pkg::MASK_W-1:0]  row_mask;
  logic [fbtc_pkg::COLOR_W-1:0] color;
  logic                         last;

  modport source (output valid, kind, pixel_index, row_mask, color, last, input ready);
  modport sink   (input valid, kind, pixel_index, row_mask, color, last, output ready);
endinterface

interface fbtc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fbtc_pkg::CFG_IDX_W-1:0] index;
  logic [fbtc_pkg::COLOR_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/fbtc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module fbtc_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [fbtc_pkg::OP_W-1:0] op_i,
  input  fbtc_pkg::ctrl_status_t    status_i,
  output fbtc_pkg::ctrl_cmd_t       cmd_o
);

  fbtc_pkg::ctrl_state_e     state_q, state_d;
  logic [fbtc_pkg::OP_W-1:0] op_q, op_d;
  logic                      accept;

  assign accept     = in_valid_i && (state_q == fbtc_pkg::S_IDLE);
  assign in_ready_o = (state_q == fbtc_pkg::S_IDLE);
  assign op_d       = accept ? op_i : op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbtc_pkg::S_IDLE;
      op_q    <= fbtc_pkg::OP_PUT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fbtc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          priority case (op_i)
            fbtc_pkg::OP_PUT:   state_d = fbtc_pkg::S_PFILL;
            fbtc_pkg::OP_SPACE: state_d = fbtc_pkg::S_ADV;
            fbtc_pkg::OP_BACK:  state_d = fbtc_pkg::S_BS;
            fbtc_pkg::OP_CLEAR: state_d = fbtc_pkg::S_CLR;
            default:            state_d = fbtc_pkg::S_IDLE;
          endcase
        end
      end
      fbtc_pkg::S_PFILL: begin
        if (!status_i.y_ge_h || status_i.can_push) state_d = fbtc_pkg::S_CHAR;
      end
      fbtc_pkg::S_CHAR: begin
        state_d = status_i.code_nl ? fbtc_pkg::S_LF : fbtc_pkg::S_START;
      end
      fbtc_pkg::S_START: state_d = fbtc_pkg::S_ROW;
      fbtc_pkg::S_ROW: begin
        // Visible rows form an unbroken run from the top of the cell.
        if (!status_i.row_ok || (status_i.can_push && status_i.row_last)) begin
          state_d = (op_q == fbtc_pkg::OP_BACK) ? fbtc_pkg::S_DONE : fbtc_pkg::S_ADV;
        end
      end
      fbtc_pkg::S_ADV: state_d = fbtc_pkg::S_WRAP;
      fbtc_pkg::S_WRAP: begin
        if (status_i.x_ge_pitch) begin
          state_d = fbtc_pkg::S_LF;
        end else begin
          state_d = (op_q == fbtc_pkg::OP_PUT) ? fbtc_pkg::S_DONE : fbtc_pkg::S_SFILL;
        end
      end
      fbtc_pkg::S_LF: state_d = fbtc_pkg::S_LFFILL;
      fbtc_pkg::S_LFFILL: begin
        if (!status_i.y_ge_h || status_i.can_push) begin
          state_d = (op_q == fbtc_pkg::OP_PUT) ? fbtc_pkg::S_DONE : fbtc_pkg::S_SFILL;
        end
      end
      fbtc_pkg::S_SFILL: begin
        if (!status_i.y_ge_h || status_i.can_push) state_d = fbtc_pkg::S_DONE;
      end
      fbtc_pkg::S_BS: begin
        state_d = status_i.at_origin ? fbtc_pkg::S_DONE : fbtc_pkg::S_START;
      end
      fbtc_pkg::S_CLR: begin
        if (status_i.can_push) state_d = fbtc_pkg::S_DONE;
      end
      fbtc_pkg::S_DONE: begin
        if (status_i.can_push) state_d = fbtc_pkg::S_IDLE;
      end
      default: state_d = fbtc_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = accept;
    cmd_o.erase  = (op_q == fbtc_pkg::OP_BACK);
    unique case (state_q)
      fbtc_pkg::S_IDLE: begin
        cmd_o.font_wr = accept && (op_i == fbtc_pkg::OP_FONT);
      end
      fbtc_pkg::S_PFILL, fbtc_pkg::S_LFFILL, fbtc_pkg::S_SFILL: begin
        cmd_o.push_fill = status_i.y_ge_h && status_i.can_push;
      end
      fbtc_pkg::S_START: cmd_o.start_rows = 1'b1;
      fbtc_pkg::S_ROW: begin
        if (status_i.row_ok && status_i.can_push) begin
          cmd_o.push_row = 1'b1;
          cmd_o.next_row = !status_i.row_last;
        end
      end
      fbtc_pkg::S_ADV: cmd_o.adv_x = 1'b1;
      fbtc_pkg::S_LF:  cmd_o.line_feed = 1'b1;
      fbtc_pkg::S_BS:  cmd_o.bs_move = !status_i.at_origin;
      fbtc_pkg::S_CLR: cmd_o.push_fill = status_i.can_push;
      fbtc_pkg::S_DONE: cmd_o.flush = status_i.can_push;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/fbtc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module fbtc_datapath #(
  parameter int GLYPH_ROWS = 16,
  parameter int FONT_CHARS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fbtc_pkg::ctrl_cmd_t            cmd_i,
  output fbtc_pkg::ctrl_status_t         status_o,
  input  logic [fbtc_pkg::CODE_W-1:0]    char_code_i,
  input  logic [fbtc_pkg::FADDR_W-1:0]   font_address_i,
  input  logic [fbtc_pkg::MASK_W-1:0]    font_byte_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fbtc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fbtc_pkg::COLOR_W-1:0]   cfg_data_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic                           res_kind_o,
  output logic [fbtc_pkg::IDX_W-1:0]     res_pixel_index_o,
  output logic [fbtc_pkg::MASK_W-1:0]    res_row_mask_o,
  output logic [fbtc_pkg::COLOR_W-1:0]   res_color_o,
  output logic                           res_last_o
);

  localparam int STORE_DEPTH = FONT_CHARS * GLYPH_ROWS;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int RW          = $clog2(GLYPH_ROWS);
  localparam int GA_W        = fbtc_pkg::CODE_W + RW + 1;
  localparam int CW          = fbtc_pkg::CUR_W;

  // Configuration registers.
  logic [CW-1:0]                  pitch_q, pitch_d, height_q, height_d;
  logic [fbtc_pkg::COLOR_W-1:0]   text_q, text_d, back_q, back_d;
  logic [CW-1:0]                  cfg_val;

  // Cursor and per-item state.
  logic [CW-1:0]                  x_q, x_d, y_q, y_d;
  logic [fbtc_pkg::CODE_W-1:0]    code_q;
  logic                           blank_q, erase_q;
  logic [RW-1:0]                  r_q, r_d;
  logic [fbtc_pkg::IDX_W-1:0]     idx_q, idx_d;

  // Glyph store.
  logic [fbtc_pkg::MASK_W-1:0]    glyph_mem [STORE_DEPTH];
  logic [fbtc_pkg::MASK_W-1:0]    rd_q;
  logic                           rd_en;
  logic [RW-1:0]                  rd_row;
  logic [AW-1:0]                  rd_addr;
  logic                           wr_en;

  // Pending and output result registers.
  logic                           pend_vld_q, pend_vld_d;
  logic                           pend_kind_q;
  logic [fbtc_pkg::IDX_W-1:0]     pend_idx_q;
  logic [fbtc_pkg::MASK_W-1:0]    pend_mask_q;
  logic [fbtc_pkg::COLOR_W-1:0]   pend_color_q;
  logic                           out_vld_q, out_vld_d;
  logic                           out_kind_q;
  logic [fbtc_pkg::IDX_W-1:0]     out_idx_q;
  logic [fbtc_pkg::MASK_W-1:0]    out_mask_q;
  logic [fbtc_pkg::COLOR_W-1:0]   out_color_q;
  logic                           out_last_q;

  logic                           push, load_out, out_free;
  logic                           new_kind;
  logic [fbtc_pkg::IDX_W-1:0]     new_idx;
  logic [fbtc_pkg::MASK_W-1:0]    new_mask;
  logic [fbtc_pkg::COLOR_W-1:0]   new_color;

  logic [CW:0]                    y_row;
  logic [2*CW-1:0]                prod;
  logic [CW-1:0]                  pitch_m1;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;
  assign cfg_val     = cfg_data_i[CW-1:0];

  always_comb begin
    pitch_d  = pitch_q;
    height_d = height_q;
    text_d   = text_q;
    back_d   = back_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fbtc_pkg::REG_PITCH: begin
          priority if (cfg_val < fbtc_pkg::MIN_PITCH) pitch_d = fbtc_pkg::MIN_PITCH;
          else if (cfg_val > fbtc_pkg::MAX_PITCH)     pitch_d = fbtc_pkg::MAX_PITCH;
          else                                        pitch_d = cfg_val;
        end
        fbtc_pkg::REG_HEIGHT: begin
          priority if (cfg_val < fbtc_pkg::MIN_HEIGHT) height_d = fbtc_pkg::MIN_HEIGHT;
          else if (cfg_val > fbtc_pkg::MAX_HEIGHT)     height_d = fbtc_pkg::MAX_HEIGHT;
          else                                         height_d = cfg_val;
        end
        fbtc_pkg::REG_TEXT: text_d = cfg_data_i;
        fbtc_pkg::REG_BACK: back_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q  <= fbtc_pkg::PITCH_RST;
      height_q <= fbtc_pkg::HEIGHT_RST;
      text_q   <= fbtc_pkg::TEXT_RST;
      back_q   <= fbtc_pkg::BACK_RST;
    end else begin
      pitch_q  <= pitch_d;
      height_q <= height_d;
      text_q   <= text_d;
      back_q   <= back_d;
    end
  end

  // ---------------------------------------------------------------- cursor
  assign pitch_m1 = pitch_q - CW'(1);
  assign prod     = (2*CW)'(y_q) * (2*CW)'(pitch_q);

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    priority if (cmd_i.push_fill) begin
      x_d = '0;
      y_d = '0;
    end else if (cmd_i.line_feed) begin
      x_d = '0;
      y_d = y_q + CW'(GLYPH_ROWS);
    end else if (cmd_i.adv_x) begin
      x_d = x_q + fbtc_pkg::CELL_WIDTH;
    end else if (cmd_i.bs_move) begin
      if (x_q == '0) begin
        // Line start: last cell position of the row above.
        y_d = (y_q >= CW'(GLYPH_ROWS)) ? y_q - CW'(GLYPH_ROWS) : '0;
        x_d = {pitch_m1[CW-1:fbtc_pkg::CELL_SH], fbtc_pkg::CELL_SH'(0)};
      end else begin
        x_d = (x_q >= fbtc_pkg::CELL_WIDTH) ? x_q - fbtc_pkg::CELL_WIDTH : '0;
      end
    end else begin
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  // ------------------------------------------------------------- row walk
  always_comb begin
    r_d   = r_q;
    idx_d = idx_q;
    if (cmd_i.start_rows) begin
      r_d   = '0;
      idx_d = fbtc_pkg::IDX_W'(prod + (2*CW)'(x_q));
    end else if (cmd_i.next_row) begin
      r_d   = r_q + RW'(1);
      idx_d = idx_q + fbtc_pkg::IDX_W'(pitch_q);
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    idx_q <= idx_d;
    if (cmd_i.accept) begin
      code_q  <= char_code_i;
      blank_q <= (int'(char_code_i) >= FONT_CHARS);
    end
    if (cmd_i.start_rows) begin
      erase_q <= cmd_i.erase;
    end
  end

  assign y_row = {1'b0, y_q} + (CW+1)'(r_q);

  // ----------------------------------------------------------- glyph store
  assign wr_en   = cmd_i.font_wr && (int'(font_address_i) < STORE_DEPTH);
  assign rd_en   = cmd_i.start_rows || cmd_i.next_row;
  assign rd_row  = cmd_i.start_rows ? '0 : r_q + RW'(1);
  assign rd_addr = AW'(GA_W'(code_q) * GA_W'(GLYPH_ROWS) + GA_W'(rd_row));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      glyph_mem[AW'(font_address_i)] <= font_byte_i;
    end
    if (rd_en) begin
      rd_q <= glyph_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------- result stage
  // A result waits in the pending register until the next one arrives or
  // the item ends, so that the final one can be marked last.
  assign push     = cmd_i.push_fill || cmd_i.push_row;
  assign out_free = !out_vld_q || res_ready_i;
  assign load_out = pend_vld_q && (push || cmd_i.flush);

  always_comb begin
    if (cmd_i.push_fill) begin
      new_kind  = fbtc_pkg::KIND_FILL;
      new_idx   = '0;
      new_mask  = fbtc_pkg::MASK_NONE;
      new_color = back_q;
    end else begin
      new_kind  = fbtc_pkg::KIND_ROW;
      new_idx   = idx_q;
      new_mask  = erase_q ? fbtc_pkg::MASK_FULL : (blank_q ? fbtc_pkg::MASK_NONE : rd_q);
      new_color = erase_q ? fbtc_pkg::ERASE_COLOR : text_q;
    end
  end

  always_comb begin
    pend_vld_d = pend_vld_q;
    if (push) begin
      pend_vld_d = 1'b1;
    end else if (cmd_i.flush) begin
      pend_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (res_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      pend_kind_q  <= new_kind;
      pend_idx_q   <= new_idx;
      pend_mask_q  <= new_mask;
      pend_color_q <= new_color;
    end
    if (load_out) begin
      out_kind_q  <= pend_kind_q;
      out_idx_q   <= pend_idx_q;
      out_mask_q  <= pend_mask_q;
      out_color_q <= pend_color_q;
      out_last_q  <= cmd_i.flush;
    end
  end

  assign res_valid_o       = out_vld_q;
  assign res_kind_o        = out_kind_q;
  assign res_pixel_index_o = out_idx_q;
  assign res_row_mask_o    = out_mask_q;
  assign res_color_o       = out_color_q;
  assign res_last_o        = out_last_q;

  // ---------------------------------------------------------------- status
  assign status_o.y_ge_h     = (y_q >= height_q);
  assign status_o.x_ge_pitch = (x_q >= pitch_q);
  assign status_o.at_origin  = (x_q == '0) && (y_q == '0);
  assign status_o.code_nl    = (code_q == fbtc_pkg::CHAR_NEWLINE);
  assign status_o.row_ok     = (y_row < {1'b0, height_q});
  assign status_o.row_last   = (r_q == RW'(GLYPH_ROWS - 1));
  assign status_o.can_push   = !pend_vld_q || out_free;

endmodule

`default_nettype wire

[rtl/core/framebuffer_text_console_unit.sv]
// Put character: after acceptance, a screen fill check, then the glyph row walk with one row
// write per visible glyph row, the cursor advance and the wrap check, and on a line wrap a
// line feed with its fill check; newline takes the line feed, space the advance, wrap and
// fill checks, backspace steps back and erases the cell's visible rows (nothing at the
// origin), clear one fill and font load ends on acceptance; a stalled output stalls the walk.
// Reset (rst_ni low, asynchronous) homes the cursor, empties the result stage and loads the
// register defaults; the glyph store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module framebuffer_text_console_unit #(
  parameter int GLYPH_ROWS = 16,
  parameter int FONT_CHARS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fbtc_cmd_if.sink  cmd_i,
  fbtc_res_if.source res_o,
  fbtc_cfg_if.sink  cfg_i
);

  fbtc_pkg::ctrl_cmd_t    cmd;
  fbtc_pkg::ctrl_status_t status;

  fbtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .op_i       (cmd_i.operation),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fbtc_datapath #(
    .GLYPH_ROWS (GLYPH_ROWS),
    .FONT_CHARS (FONT_CHARS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .char_code_i       (cmd_i.char_code),
    .font_address_i    (cmd_i.font_address),
    .font_byte_i       (cmd_i.font_byte),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_ready_o       (cfg_i.ready),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .res_valid_o       (res_o.valid),
    .res_ready_i       (res_o.ready),
    .res_kind_o        (res_o.kind),
    .res_pixel_index_o (res_o.pixel_index),
    .res_row_mask_o    (res_o.row_mask),
    .res_color_o       (res_o.color),
    .res_last_o        (res_o.last)
  );

endmodule

`default_nettype wire

[rtl/core/fbtc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "framebuffer_text_console_unit_defines.svh"

module fbtc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cmd_valid_i,
  input logic                         cmd_ready_i,
  input logic [fbtc_pkg::OP_W-1:0]    cmd_operation_i,
  input logic                         res_valid_i,
  input logic                         res_ready_i,
  input logic                         res_kind_i,
  input logic [fbtc_pkg::IDX_W-1:0]   res_pixel_index_i,
  input logic [fbtc_pkg::MASK_W-1:0]  res_row_mask_i,
  input logic [fbtc_pkg::COLOR_W-1:0] res_color_i,
  input logic                         res_last_i
);

  // A stalled result keeps its contents.
  `FBTC_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_kind_i) && $stable(res_pixel_index_i) && $stable(res_row_mask_i) && $stable(res_color_i) && $stable(res_last_i), "result changed while stalled")

  // While an item still has results to come, no new command is taken.
  `FBTC_ASSERT(a_busy_mid_item, (res_valid_i && !res_last_i) |-> !cmd_ready_i, "command ready in the middle of an item")

  // A clear always produces a fill, so the unit is busy the next cycle.
  `FBTC_ASSERT_NEXT(a_clear_busy, cmd_valid_i && cmd_ready_i && (cmd_operation_i == fbtc_pkg::OP_CLEAR), !cmd_ready_i, "clear did not occupy the unit")

  // A font byte load completes in the cycle it is taken.
  `FBTC_ASSERT_NEXT(a_font_free, cmd_valid_i && cmd_ready_i && (cmd_operation_i == fbtc_pkg::OP_FONT), cmd_ready_i, "font load left the unit busy")

endmodule

bind framebuffer_text_console_unit fbtc_checker u_fbtc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .cmd_valid_i       (cmd_i.valid),
  .cmd_ready_i       (cmd_i.ready),
  .cmd_operation_i   (cmd_i.operation),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .res_kind_i        (res_o.kind),
  .res_pixel_index_i (res_o.pixel_index),
  .res_row_mask_i    (res_o.row_mask),
  .res_color_i       (res_o.color),
  .res_last_i        (res_o.last)
);

`default_nettype wire
